// ===== rtl/dspt_pkg.sv =====
`default_nettype none
package dspt_pkg;
    localparam int MaxLen   = 4096;
    localparam int AddrW    = $clog2(MaxLen);
    localparam int CountW   = AddrW + 1;
    localparam int ValW     = 16;
    localparam int LagW     = 13;
    localparam int AccW     = 2 * ValW + CountW;
    localparam int TotW     = ValW + CountW + 1;
    localparam logic [15:0] CiReset = 16'd62259;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                   last;
        logic                   pass;
        logic signed [LagW-1:0] lag;
    } t_tag;
endpackage
`default_nettype wire

// ===== rtl/diagonal_sum_peak_and_tail.sv =====
`default_nettype none
// diagonal sum peak and tail search
// input channel (i_valid/o_ready): one x/y element pair per item, i_last marks
// the final pair; i_side_negative is taken with the last pair. pairs beyond
// 4096 are dropped, the last flag still starts a run on what is held.
// config channel (i_cfg_valid/o_cfg_ready): writes ci_fraction, always ready;
// write only while the block is idle.
// output channel (o_valid/i_ready): one result item per last pair.
// each non-last item is only stored. a last item starts a run that visits
// every diagonal of the outer product with a single multiply-accumulate fed
// by the two element memories, one product per cycle, so a run of n pairs
// computes n*n products.
// the input stays not ready during the run and until the result has been
// moved to the output register; a stalled receiver holds the result there
// and the next run's result waits for it to drain.
// reset clears the element count and length, side, state, valid flags and ci_fraction
// (to 62259); the element memories are not cleared, a run only reads entries of the current load.
module diagonal_sum_peak_and_tail (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_x_value,
    input  wire logic [15:0] i_y_value,
    input  wire logic        i_side_negative,
    input  wire logic        i_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [12:0] o_peak_lag,
    output logic [16:0]      o_p_value,
    output logic signed [12:0] o_low_ci_lag,
    output logic             o_low_ci_found,
    output logic signed [12:0] o_high_ci_lag,
    output logic             o_high_ci_found
);
    localparam int AW = dspt_pkg::AddrW;
    localparam int CW = dspt_pkg::CountW;
    localparam int LW = dspt_pkg::LagW;

    // element memories
    logic [15:0] r_x_mem [dspt_pkg::MaxLen];
    logic [15:0] r_y_mem [dspt_pkg::MaxLen];

    dspt_pkg::t_state r_state, n_state;
    logic [15:0]   r_ci;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic          r_side;

    // issue counters
    logic          r_pass;
    logic [CW-1:0] r_k, r_i;
    logic          issue_last, issue_done;

    // pipeline
    logic [15:0]   r_xd, r_yd;
    logic          r_v1, r_v2, r_v3;
    dspt_pkg::t_tag r_t1, r_t2, r_t3;
    logic [31:0]   r_prod;
    logic [dspt_pkg::AccW-1:0] r_acc;
    logic [dspt_pkg::AccW-1:0] acc_sum;
    logic [15:0]   r_d;

    // run results
    logic [15:0]   r_pmax;
    logic signed [LW-1:0] r_pmax_lag, r_low_lag, r_high_lag;
    logic          r_low_found, r_high_found;
    logic [dspt_pkg::TotW-1:0] r_total, r_s, tot_next;

    logic          in_acc, run_start, plus;
    logic [CW-1:0] sum_ik;
    logic [AW-1:0] x_addr, y_addr;
    logic          out_load;
    logic [16:0]   s_fold;
    logic          use_ci, peak_take;

    assign in_acc    = i_valid && o_ready;
    assign run_start = in_acc && i_last;
    assign o_cfg_ready = 1'b1;
    assign use_ci    = r_ci != 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= dspt_pkg::CiReset;
        end else if (i_cfg_valid) begin
            r_ci <= i_cfg_data;
        end
    end

    // load side
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CW'(dspt_pkg::MaxLen)) begin
            r_x_mem[r_count[AW-1:0]] <= i_x_value;
            r_y_mem[r_count[AW-1:0]] <= i_y_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_side  <= 1'b0;
            r_n     <= '0;
        end else if (run_start) begin
            r_count <= '0;
            r_side  <= i_side_negative;
            r_n     <= (r_count < CW'(dspt_pkg::MaxLen)) ? r_count + 1'b1 : r_count;
        end else if (in_acc && r_count < CW'(dspt_pkg::MaxLen)) begin
            r_count <= r_count + 1'b1;
        end
    end

    // state machine
    assign out_load = (r_state == dspt_pkg::ST_DONE) && (!o_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dspt_pkg::ST_IDLE:  if (run_start) n_state = dspt_pkg::ST_RUN;
            dspt_pkg::ST_RUN:   if (issue_done) n_state = dspt_pkg::ST_DRAIN;
            dspt_pkg::ST_DRAIN: if (!r_v1 && !r_v2 && !r_v3) n_state = dspt_pkg::ST_DONE;
            dspt_pkg::ST_DONE:  if (out_load) n_state = dspt_pkg::ST_IDLE;
            default:            n_state = dspt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == dspt_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dspt_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // issue: one product address pair per cycle
    assign sum_ik     = r_i + r_k;
    assign issue_last = (sum_ik == r_n - 1'b1);
    assign plus       = (r_pass == 1'b0) == (r_side == 1'b0);
    assign x_addr     = plus ? sum_ik[AW-1:0] : r_i[AW-1:0];
    assign y_addr     = plus ? r_i[AW-1:0] : sum_ik[AW-1:0];
    assign issue_done = issue_last &&
                        ((r_pass == 1'b0 && r_k == '0 && r_n == CW'(1)) ||
                         (r_pass == 1'b1 && r_k == r_n - 1'b1));

    always_ff @(posedge i_clk) begin
        if (run_start) begin
            r_pass <= 1'b0;
            r_i    <= '0;
            r_k    <= (r_count < CW'(dspt_pkg::MaxLen)) ? r_count : r_count - 1'b1;
        end else if (r_state == dspt_pkg::ST_RUN) begin
            if (issue_last) begin
                r_i <= '0;
                if (r_pass == 1'b0) begin
                    if (r_k == '0) begin
                        r_pass <= 1'b1;
                        r_k    <= CW'(1);
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    // memory read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_xd <= r_x_mem[x_addr];
        r_yd <= r_y_mem[y_addr];
        r_t1.last <= issue_last;
        r_t1.pass <= r_pass;
        r_t1.lag  <= plus ? r_k : LW'(-r_k);
        r_prod <= r_xd * r_yd;
        r_t2   <= r_t1;
        r_t3   <= r_t2;
    end

    assign acc_sum = r_acc + dspt_pkg::AccW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == dspt_pkg::ST_RUN);
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_t2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            if (r_t2.last) begin
                r_acc <= '0;
                // truncate to q0.16, saturate at all ones
                r_d <= (acc_sum[dspt_pkg::AccW-1:32] != '0) ? 16'hFFFF : acc_sum[31:16];
            end else begin
                r_acc <= acc_sum;
            end
        end
    end

    // peak, running totals, thresholds
    assign tot_next  = r_total + dspt_pkg::TotW'(r_d);
    assign peak_take = r_t3.pass ? (r_pmax < r_d) : (r_pmax <= r_d);

    always_ff @(posedge i_clk) begin
        if (run_start) begin
            r_pmax       <= '0;
            r_pmax_lag   <= '0;
            r_total      <= '0;
            r_s          <= '0;
            r_low_found  <= 1'b0;
            r_high_found <= 1'b0;
            r_low_lag    <= '0;
            r_high_lag   <= '0;
        end else if (r_v3) begin
            if (peak_take) begin
                r_pmax     <= r_d;
                r_pmax_lag <= r_t3.lag;
            end
            if (r_t3.pass) r_s <= r_s + dspt_pkg::TotW'(r_d);
            r_total <= tot_next;
            if (use_ci && !r_low_found &&
                {tot_next, 1'b0} >= (dspt_pkg::TotW+1)'(18'h10000 - {2'b00, r_ci})) begin
                r_low_found <= 1'b1;
                r_low_lag   <= r_t3.lag;
            end
            if (use_ci && !r_high_found &&
                {tot_next, 1'b0} >= (dspt_pkg::TotW+1)'(18'h10000 + {2'b00, r_ci})) begin
                r_high_found <= 1'b1;
                r_high_lag   <= r_t3.lag;
            end
        end
    end

    // fold the second-pass mass into the smaller tail
    always_comb begin
        if (r_s > dspt_pkg::TotW'(32768)) begin
            s_fold = (r_s >= dspt_pkg::TotW'(65536)) ? 17'd0
                   : 17'(dspt_pkg::TotW'(65536) - r_s);
        end else begin
            s_fold = r_s[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_peak_lag      <= r_pmax_lag;
            o_p_value       <= {s_fold[15:0], 1'b0};
            o_low_ci_lag    <= r_low_lag;
            o_low_ci_found  <= r_low_found;
            o_high_ci_lag   <= r_high_lag;
            o_high_ci_found <= r_high_found;
        end
    end
endmodule
`default_nettype wire

// ===== dv/diagonal_sum_peak_and_tail_tb.sv =====
`timescale 1ns / 1ps

typedef struct {
    logic [12:0] peak_lag;
    logic [16:0] p_value;
    logic [12:0] low_lag;
    logic        low_found;
    logic [12:0] high_lag;
    logic        high_found;
} t_peak_result;

class peak_scoreboard;
    bit [15:0]    x_store[dspt_pkg::MaxLen];
    bit [15:0]    y_store[dspt_pkg::MaxLen];
    int unsigned  held;
    bit [15:0]    ci;
    t_peak_result pending[$];
    int unsigned  errors;
    int unsigned  runs;

    function new();
        held   = 0;
        ci     = dspt_pkg::CiReset;
        errors = 0;
        runs   = 0;
    endfunction

    // truncated, saturated diagonal sum; plus: x[i+k]*y[i]
    function bit [15:0] diag_sum(int unsigned k, bit plus);
        longint unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i + k < held; i++) begin
            if (plus) acc += {48'd0, x_store[i + k]} * {48'd0, y_store[i]};
            else acc += {48'd0, y_store[i + k]} * {48'd0, x_store[i]};
        end
        acc = acc >> 16;
        return (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
    endfunction

    function void note_pair(bit [15:0] x, bit [15:0] y, bit side, bit last);
        t_peak_result    r;
        int unsigned     steps, k;
        bit [15:0]       d, peak;
        int              lag, peak_lag, low_lag, high_lag;
        bit              low_hit, high_hit, plus;
        longint unsigned total, tail, low_thr, high_thr;
        if (held < dspt_pkg::MaxLen) begin
            x_store[held] = x;
            y_store[held] = y;
            held++;
        end
        if (!last) return;
        peak = 0; peak_lag = 0; low_lag = 0; high_lag = 0;
        low_hit = 0; high_hit = 0; total = 0; tail = 0;
        low_thr  = 65536 - ci;
        high_thr = 65536 + ci;
        for (int pass = 0; pass < 2; pass++) begin
            steps = (pass == 0) ? held : held - 1;
            for (int unsigned t = 0; t < steps; t++) begin
                k    = (pass == 0) ? held - 1 - t : t + 1;
                plus = ((pass == 0) == (side == 0));
                d    = diag_sum(k, plus);
                lag  = plus ? int'(k) : -int'(k);
                if ((pass == 0) ? (peak <= d) : (peak < d)) begin
                    peak     = d;
                    peak_lag = lag;
                end
                if (pass == 1) tail += d;
                total += d;
                if (ci != 0 && !low_hit && 2 * total >= low_thr) begin
                    low_hit = 1;
                    low_lag = lag;
                end
                if (ci != 0 && !high_hit && 2 * total >= high_thr) begin
                    high_hit = 1;
                    high_lag = lag;
                end
            end
        end
        // fold the tail mass to the smaller side
        if (tail > 32768) tail = (tail >= 65536) ? 0 : 65536 - tail;
        r.peak_lag   = peak_lag[12:0];
        r.p_value    = 17'(2 * tail);
        r.low_lag    = low_lag[12:0];
        r.low_found  = low_hit;
        r.high_lag   = high_lag[12:0];
        r.high_found = high_hit;
        pending.push_back(r);
        held = 0;
        runs++;
    endfunction

    function void check_result(t_peak_result got);
        t_peak_result w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, peak_lag %0d", $time, $signed(got.peak_lag));
            errors++;
            return;
        end
        w = pending.pop_front();
        if (got.peak_lag !== w.peak_lag) begin
            $display("%0t: peak_lag exp %0d got %0d", $time,
                     $signed(w.peak_lag), $signed(got.peak_lag));
            errors++;
        end
        if (got.p_value !== w.p_value) begin
            $display("%0t: p_value exp %0d got %0d", $time, w.p_value, got.p_value);
            errors++;
        end
        if (got.low_lag !== w.low_lag || got.low_found !== w.low_found) begin
            $display("%0t: low ci exp %0d/%0b got %0d/%0b", $time, $signed(w.low_lag),
                     w.low_found, $signed(got.low_lag), got.low_found);
            errors++;
        end
        if (got.high_lag !== w.high_lag || got.high_found !== w.high_found) begin
            $display("%0t: high ci exp %0d/%0b got %0d/%0b", $time, $signed(w.high_lag),
                     w.high_found, $signed(got.high_lag), got.high_found);
            errors++;
        end
    endfunction
endclass

module diagonal_sum_peak_and_tail_tb;
    localparam int StallLimit = 200000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [15:0] i_x_value = 0;
    logic [15:0] i_y_value = 0;
    logic        i_side_negative = 0;
    logic        i_last = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic signed [12:0] o_peak_lag;
    logic [16:0] o_p_value;
    logic signed [12:0] o_low_ci_lag;
    logic        o_low_ci_found;
    logic signed [12:0] o_high_ci_lag;
    logic        o_high_ci_found;

    peak_scoreboard sb = new();
    int unsigned    pairs_sent = 0;
    int unsigned    longest = 0;
    bit             quiet = 0;    // no idling on either side while set
    bit             running = 0;  // receiver active once out of reset
    int unsigned    stall_count = 0;

    diagonal_sum_peak_and_tail uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_x_value(i_x_value), .i_y_value(i_y_value),
        .i_side_negative(i_side_negative), .i_last(i_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_peak_lag(o_peak_lag), .o_p_value(o_p_value),
        .o_low_ci_lag(o_low_ci_lag), .o_low_ci_found(o_low_ci_found),
        .o_high_ci_lag(o_high_ci_lag), .o_high_ci_found(o_high_ci_found)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // receiver: ready drops in about one cycle of ten unless quiet
    always @(negedge i_clk) begin
        i_ready <= running && (quiet || $urandom_range(99) >= 10);
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        t_peak_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.peak_lag   = o_peak_lag;
            got.p_value    = o_p_value;
            got.low_lag    = o_low_ci_lag;
            got.low_found  = o_low_ci_found;
            got.high_lag   = o_high_ci_lag;
            got.high_found = o_high_ci_found;
            sb.check_result(got);
        end
    end

    // watchdog: cycles without any handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= StallLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("simulation failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // one element pair; after a non-last pair valid stays high into the next item when no gap
    task automatic push_pair(bit [15:0] x, bit [15:0] y, bit side, bit last);
        if (!quiet && $urandom_range(99) < 10) begin
            i_valid = 0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_valid         = 1;
        i_x_value       = x;
        i_y_value       = y;
        i_side_negative = side;
        i_last          = last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pair(x, y, side, last);
        pairs_sent++;
        @(negedge i_clk);
        if (last) i_valid = 0;
    endtask

    // ci writes only once every result is back and the block has settled
    task automatic write_ci(bit [15:0] value);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.ci = value;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // one whole vector pair; flavor picks the value profile
    task automatic send_vector(int unsigned n, int flavor, bit side);
        bit [15:0] x, y;
        int unsigned cap;
        if (n > longest) longest = n;
        cap = 65536 / n;
        for (int unsigned i = 0; i < n; i++) begin
            case (flavor)
                0: begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                1: begin   // density-like, sums land near one
                    x = 16'($urandom_range(2 * cap > 65535 ? 65535 : 2 * cap));
                    y = 16'($urandom_range(2 * cap > 65535 ? 65535 : 2 * cap));
                end
                2: begin
                    x = 16'hFFFF;
                    y = 16'hFFFF;
                end
                3: begin   // sparse spikes
                    x = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
                    y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
                end
                default: begin
                    x = 16'd1 << $urandom_range(15);
                    y = ~(16'd1 << $urandom_range(15));
                end
            endcase
            push_pair(x, y, side, i == n - 1);
        end
    endtask

    initial begin
        int unsigned n, vectors;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        running = 1;

        // directed: reset ci, single pair, saturation, zeros, both sides
        push_pair(16'hFFFF, 16'hFFFF, 0, 1);
        send_vector(2, 2, 0);
        send_vector(3, 2, 1);
        push_pair(16'h0000, 16'h0000, 1, 0);
        push_pair(16'h0000, 16'h0000, 1, 1);
        // mass at the far end so the first pass carries all of it
        push_pair(16'h0000, 16'hFFFF, 0, 0);
        push_pair(16'h0000, 16'h0000, 0, 0);
        push_pair(16'hFFFF, 16'h0000, 0, 1);
        push_pair(16'h8000, 16'h0000, 1, 0);
        push_pair(16'h0000, 16'h8000, 1, 1);
        write_ci(16'd0);
        send_vector(3, 1, 0);
        write_ci(16'hFFFF);
        send_vector(4, 1, 1);
        write_ci(16'd1);
        send_vector(3, 0, 0);

        // random: mostly short vectors, a few long ones
        vectors = 0;
        while (pairs_sent < 1650) begin
            if (vectors % 25 == 0) begin
                case ($urandom_range(4))
                    0: write_ci(16'd0);
                    1: write_ci(16'hFFFF);
                    2: write_ci(dspt_pkg::CiReset);
                    default: write_ci(16'($urandom));
                endcase
            end
            quiet = (vectors >= 40 && vectors < 70);
            if ($urandom_range(99) < 2) n = $urandom_range(160, 64);
            else if ($urandom_range(9) == 0) n = 1;
            else n = $urandom_range(24, 2);
            send_vector(n, ($urandom_range(9) < 5) ? 1 : $urandom_range(4),
                        1'($urandom_range(1)));
            vectors++;
        end
        quiet = 0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("covered %0d element pairs in %0d runs, longest vector %0d pairs",
                 pairs_sent, sb.runs, longest);
        $display("ci settings included zero, full scale, one and reset value");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/dspt_pkg.sv
rtl/diagonal_sum_peak_and_tail.sv
dv/diagonal_sum_peak_and_tail_tb.sv
